// ----- src/rm2q_pkg.sv -----
// Shared constants and types for the rotation matrix to quaternion converter.
package rm2q_pkg;

    localparam int FRAC_BITS = 14;
    localparam int DATA_W    = 16;
    localparam int ARG_W     = 17;
    localparam int MAG_W     = 17;
    localparam int RAD_W     = 32;
    localparam int SQ_STEPS  = RAD_W / 2;
    localparam int ROOT_W    = SQ_STEPS;
    localparam int HALF_W    = ROOT_W - 1;
    localparam int DEN_W     = HALF_W + 2;
    localparam int REM_W     = 32;
    localparam int QUO_W     = 15;
    localparam int SQR_W     = ROOT_W + 2;
    localparam int NDV       = QUO_W;

    localparam logic [1:0] BR_TRACE = 2'd0;
    localparam logic [1:0] BR_X     = 2'd1;
    localparam logic [1:0] BR_Y     = 2'd2;
    localparam logic [1:0] BR_Z     = 2'd3;

    typedef struct packed {
        logic [1:0] br;
        logic       dg;
        logic [2:0] dneg;
    } side_t;

endpackage

// ----- src/rm2q_in_if.sv -----
// Matrix input channel: valid, ready and the nine matrix elements.
interface rm2q_in_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] r_xx;
    logic signed [15:0] r_xy;
    logic signed [15:0] r_xz;
    logic signed [15:0] r_yx;
    logic signed [15:0] r_yy;
    logic signed [15:0] r_yz;
    logic signed [15:0] r_zx;
    logic signed [15:0] r_zy;
    logic signed [15:0] r_zz;

    modport source (output valid, r_xx, r_xy, r_xz, r_yx, r_yy, r_yz, r_zx, r_zy, r_zz,
                    input ready);
    modport sink (input valid, r_xx, r_xy, r_xz, r_yx, r_yy, r_yz, r_zx, r_zy, r_zz,
                  output ready);
endinterface

// ----- src/rm2q_out_if.sv -----
// Quaternion output channel: valid, ready, components, branch and flag.
interface rm2q_out_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] q_x;
    logic signed [15:0] q_y;
    logic signed [15:0] q_z;
    logic signed [15:0] q_w;
    logic [1:0]         branch_used;
    logic               degenerate;

    modport source (output valid, q_x, q_y, q_z, q_w, branch_used, degenerate,
                    input ready);
    modport sink (input valid, q_x, q_y, q_z, q_w, branch_used, degenerate,
                  output ready);
endinterface

// ----- src/rotation_matrix_to_quaternion.sv -----
// Pipelined fixed-point rotation matrix to quaternion converter (top level).
//
//  channel  | dir | payload                                        | handshake
//  ---------+-----+------------------------------------------------+----------
//  matrix   | in  | r_xx .. r_zz, signed Q1.14                     | valid/ready
//  quat     | out | q_x q_y q_z q_w, branch_used, degenerate       | valid/ready
//
// One matrix enters per cycle while the pipe advances; in the pipe, one
// stage picks the branch, 16 stages run the square root one result bit each,
// one stage forms the divider operands, 15 stages run the three dividers one
// quotient bit each, and the last stage saturates and places the components.
// Reset clears only the valid bits. When the output beat is not taken the
// whole pipe holds, so nothing is lost or repeated under a stall.
module rotation_matrix_to_quaternion
    import rm2q_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    rm2q_in_if.sink     matrix,
    rm2q_out_if.source  quat
);

    // The whole pipe moves together whenever the output register is free.
    logic adv;
    logic out_valid_reg;
    assign adv = !out_valid_reg || quat.ready;
    assign matrix.ready = adv;

    // ------------------------------------------------------------------
    // Branch selection. A branch is taken when its argument is positive;
    // any positive argument gives a nonzero half root, so the sign alone
    // decides. The three other components use sums or differences of the
    // off-diagonal elements, kept as magnitude and sign, in x y z w order.
    // ------------------------------------------------------------------
    logic signed [ARG_W:0]   one_s;
    logic signed [ARG_W:0]   xx_s, yy_s, zz_s;
    logic signed [ARG_W:0]   a0, a1, a2, a3;
    logic signed [MAG_W-1:0] d_zy_yz, d_xz_zx, d_yx_xy, s_xy, s_xz, s_yz;
    logic signed [MAG_W-1:0] dsel [3];
    logic [ARG_W-1:0]        arg_next;
    side_t                   side_next;
    logic [MAG_W-1:0]        dmag_next [3];

    always_comb
    begin
        one_s = (ARG_W+1)'(1) <<< FRAC_BITS;
        xx_s  = (ARG_W+1)'(matrix.r_xx);
        yy_s  = (ARG_W+1)'(matrix.r_yy);
        zz_s  = (ARG_W+1)'(matrix.r_zz);
        a0 = one_s + xx_s + yy_s + zz_s;
        a1 = one_s + xx_s - yy_s - zz_s;
        a2 = one_s - xx_s + yy_s - zz_s;
        a3 = one_s - xx_s - yy_s + zz_s;
        d_zy_yz = MAG_W'(matrix.r_zy) - MAG_W'(matrix.r_yz);
        d_xz_zx = MAG_W'(matrix.r_xz) - MAG_W'(matrix.r_zx);
        d_yx_xy = MAG_W'(matrix.r_yx) - MAG_W'(matrix.r_xy);
        s_xy    = MAG_W'(matrix.r_xy) + MAG_W'(matrix.r_yx);
        s_xz    = MAG_W'(matrix.r_xz) + MAG_W'(matrix.r_zx);
        s_yz    = MAG_W'(matrix.r_yz) + MAG_W'(matrix.r_zy);
        side_next.dg = 1'b0;
        if (a0 > 0)
        begin
            side_next.br = BR_TRACE;
            arg_next = a0[ARG_W-1:0];
            dsel[0] = d_zy_yz;
            dsel[1] = d_xz_zx;
            dsel[2] = d_yx_xy;
        end
        else if (a1 > 0)
        begin
            side_next.br = BR_X;
            arg_next = a1[ARG_W-1:0];
            dsel[0] = s_xy;
            dsel[1] = s_xz;
            dsel[2] = d_zy_yz;
        end
        else if (a2 > 0)
        begin
            side_next.br = BR_Y;
            arg_next = a2[ARG_W-1:0];
            dsel[0] = s_xy;
            dsel[1] = s_yz;
            dsel[2] = d_xz_zx;
        end
        else
        begin
            side_next.br = BR_Z;
            dsel[0] = s_xz;
            dsel[1] = s_yz;
            dsel[2] = d_yx_xy;
            if (a3 > 0)
            begin
                arg_next = a3[ARG_W-1:0];
            end
            else
            begin
                arg_next = '0;
                side_next.dg = 1'b1;
            end
        end
        for (int j = 0; j < 3; j++)
        begin
            side_next.dneg[j] = dsel[j][MAG_W-1];
            dmag_next[j] = dsel[j][MAG_W-1] ? MAG_W'(-dsel[j]) : MAG_W'(dsel[j]);
        end
    end

    // ------------------------------------------------------------------
    // Square root, one result bit per stage. Index 0 is the branch stage.
    // ------------------------------------------------------------------
    logic                 sq_v_reg    [SQ_STEPS+1];
    side_t                sq_side_reg [SQ_STEPS+1];
    logic [MAG_W-1:0]     sq_dmag_reg [SQ_STEPS+1][3];
    logic [RAD_W-1:0]     sq_rad_reg  [SQ_STEPS+1];
    logic [SQR_W-1:0]     sq_rem_reg  [SQ_STEPS+1];
    logic [ROOT_W-1:0]    sq_root_reg [SQ_STEPS+1];
    logic [RAD_W-1:0]     sq_rad_next  [SQ_STEPS+1];
    logic [SQR_W-1:0]     sq_rem_next  [SQ_STEPS+1];
    logic [ROOT_W-1:0]    sq_root_next [SQ_STEPS+1];
    logic [SQR_W-1:0]     sq_trial [SQ_STEPS];
    logic [SQR_W-1:0]     sq_part  [SQ_STEPS];

    always_comb
    begin
        sq_rad_next[0]  = RAD_W'(arg_next) << FRAC_BITS;
        sq_rem_next[0]  = '0;
        sq_root_next[0] = '0;
        for (int k = 0; k < SQ_STEPS; k++)
        begin
            sq_part[k]  = {sq_rem_reg[k][SQR_W-3:0], sq_rad_reg[k][RAD_W-1 -: 2]};
            sq_trial[k] = {sq_root_reg[k], 2'b01};
            sq_rad_next[k+1] = sq_rad_reg[k] << 2;
            if (sq_part[k] >= sq_trial[k])
            begin
                sq_rem_next[k+1]  = sq_part[k] - sq_trial[k];
                sq_root_next[k+1] = {sq_root_reg[k][ROOT_W-2:0], 1'b1};
            end
            else
            begin
                sq_rem_next[k+1]  = sq_part[k];
                sq_root_next[k+1] = {sq_root_reg[k][ROOT_W-2:0], 1'b0};
            end
        end
    end

    // ------------------------------------------------------------------
    // Divider operands and restoring division, one quotient bit per stage.
    // The numerator is |D| shifted up plus 2r, the divisor 4r. A quotient
    // of 2^15 or more is flagged up front, so the stages need 15 bits.
    // ------------------------------------------------------------------
    logic                 dv_v_reg    [NDV+1];
    side_t                dv_side_reg [NDV+1];
    logic [HALF_W-1:0]    dv_r_reg    [NDV+1];
    logic [DEN_W-1:0]     dv_den_reg  [NDV+1];
    logic [2:0]           dv_ovf_reg  [NDV+1];
    logic [REM_W-1:0]     dv_rem_reg  [NDV+1][3];
    logic [QUO_W-1:0]     dv_q_reg    [NDV+1][3];
    logic [REM_W-1:0]     dv_rem_next [NDV+1][3];
    logic [QUO_W-1:0]     dv_q_next   [NDV+1][3];
    logic [2:0]           ovf_next;
    logic [HALF_W-1:0]    half_root;
    logic [DEN_W-1:0]     den_next;
    logic [REM_W-1:0]     dv_sub [NDV][3];

    always_comb
    begin
        half_root = sq_root_reg[SQ_STEPS][ROOT_W-1:1];
        den_next  = {half_root, 2'b00};
        for (int j = 0; j < 3; j++)
        begin
            dv_rem_next[0][j] = (REM_W'(sq_dmag_reg[SQ_STEPS][j]) << FRAC_BITS)
                              + REM_W'({half_root, 1'b0});
            dv_q_next[0][j]   = '0;
            ovf_next[j] = dv_rem_next[0][j] >= (REM_W'(den_next) << QUO_W);
        end
        for (int k = 0; k < NDV; k++)
        begin
            for (int j = 0; j < 3; j++)
            begin
                dv_sub[k][j] = REM_W'(dv_den_reg[k]) << (QUO_W - 1 - k);
                if (dv_rem_reg[k][j] >= dv_sub[k][j])
                begin
                    dv_rem_next[k+1][j] = dv_rem_reg[k][j] - dv_sub[k][j];
                    dv_q_next[k+1][j]   = {dv_q_reg[k][j][QUO_W-2:0], 1'b1};
                end
                else
                begin
                    dv_rem_next[k+1][j] = dv_rem_reg[k][j];
                    dv_q_next[k+1][j]   = {dv_q_reg[k][j][QUO_W-2:0], 1'b0};
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Output formatting: saturate the three quotients, place the root.
    // ------------------------------------------------------------------
    logic signed [DATA_W-1:0] comp [3];
    logic signed [DATA_W-1:0] root_c;
    logic signed [DATA_W-1:0] qx_next, qy_next, qz_next, qw_next;
    side_t                    fin;

    always_comb
    begin
        fin    = dv_side_reg[NDV];
        root_c = DATA_W'(dv_r_reg[NDV]);
        for (int j = 0; j < 3; j++)
        begin
            if (fin.dneg[j])
            begin
                comp[j] = dv_ovf_reg[NDV][j] ? DATA_W'(16'sh8000)
                        : -DATA_W'(dv_q_reg[NDV][j]);
            end
            else
            begin
                comp[j] = dv_ovf_reg[NDV][j] ? DATA_W'(16'sh7fff)
                        : DATA_W'(dv_q_reg[NDV][j]);
            end
        end
        qx_next = comp[0];
        qy_next = comp[1];
        qz_next = comp[2];
        qw_next = root_c;
        unique case (fin.br)
            BR_TRACE:
            begin
                qw_next = root_c;
            end
            BR_X:
            begin
                qx_next = root_c;
                qy_next = comp[0];
                qz_next = comp[1];
                qw_next = comp[2];
            end
            BR_Y:
            begin
                qy_next = root_c;
                qz_next = comp[1];
                qw_next = comp[2];
            end
            BR_Z:
            begin
                qz_next = root_c;
                qw_next = comp[2];
            end
            default:
            begin
                qw_next = root_c;
            end
        endcase
        if (fin.dg)
        begin
            qx_next = '0;
            qy_next = '0;
            qz_next = '0;
            qw_next = '0;
        end
    end

    // ------------------------------------------------------------------
    // Registers.
    // ------------------------------------------------------------------
    logic signed [DATA_W-1:0] q_x_reg, q_y_reg, q_z_reg, q_w_reg;
    logic [1:0]               branch_reg;
    logic                     degen_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k <= SQ_STEPS; k++)
            begin
                sq_v_reg[k] <= 1'b0;
            end
            for (int k = 0; k <= NDV; k++)
            begin
                dv_v_reg[k] <= 1'b0;
            end
            out_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            sq_v_reg[0] <= matrix.valid;
            for (int k = 0; k < SQ_STEPS; k++)
            begin
                sq_v_reg[k+1] <= sq_v_reg[k];
            end
            dv_v_reg[0] <= sq_v_reg[SQ_STEPS];
            for (int k = 0; k < NDV; k++)
            begin
                dv_v_reg[k+1] <= dv_v_reg[k];
            end
            out_valid_reg <= dv_v_reg[NDV];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            sq_side_reg[0] <= side_next;
            sq_rad_reg[0]  <= sq_rad_next[0];
            sq_rem_reg[0]  <= sq_rem_next[0];
            sq_root_reg[0] <= sq_root_next[0];
            for (int j = 0; j < 3; j++)
            begin
                sq_dmag_reg[0][j] <= dmag_next[j];
            end
            for (int k = 0; k < SQ_STEPS; k++)
            begin
                sq_side_reg[k+1] <= sq_side_reg[k];
                sq_rad_reg[k+1]  <= sq_rad_next[k+1];
                sq_rem_reg[k+1]  <= sq_rem_next[k+1];
                sq_root_reg[k+1] <= sq_root_next[k+1];
                for (int j = 0; j < 3; j++)
                begin
                    sq_dmag_reg[k+1][j] <= sq_dmag_reg[k][j];
                end
            end
            dv_side_reg[0] <= sq_side_reg[SQ_STEPS];
            dv_r_reg[0]    <= half_root;
            dv_den_reg[0]  <= den_next;
            dv_ovf_reg[0]  <= ovf_next;
            for (int j = 0; j < 3; j++)
            begin
                dv_rem_reg[0][j] <= dv_rem_next[0][j];
                dv_q_reg[0][j]   <= dv_q_next[0][j];
            end
            for (int k = 0; k < NDV; k++)
            begin
                dv_side_reg[k+1] <= dv_side_reg[k];
                dv_r_reg[k+1]    <= dv_r_reg[k];
                dv_den_reg[k+1]  <= dv_den_reg[k];
                dv_ovf_reg[k+1]  <= dv_ovf_reg[k];
                for (int j = 0; j < 3; j++)
                begin
                    dv_rem_reg[k+1][j] <= dv_rem_next[k+1][j];
                    dv_q_reg[k+1][j]   <= dv_q_next[k+1][j];
                end
            end
            q_x_reg    <= qx_next;
            q_y_reg    <= qy_next;
            q_z_reg    <= qz_next;
            q_w_reg    <= qw_next;
            branch_reg <= fin.br;
            degen_reg  <= fin.dg;
        end
    end

    assign quat.valid       = out_valid_reg;
    assign quat.q_x         = q_x_reg;
    assign quat.q_y         = q_y_reg;
    assign quat.q_z         = q_z_reg;
    assign quat.q_w         = q_w_reg;
    assign quat.branch_used = branch_reg;
    assign quat.degenerate  = degen_reg;

endmodule
